@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ sv/epbt_pkg.sv @@
// ----------------------------------------------------------------------------
// epbt_pkg
// Types, constants and stage functions of the period bucket transform.
// ----------------------------------------------------------------------------
package epbt_pkg;

	localparam int NS = 23;

	localparam logic [2:0] ACT_DATE_YEAR  = 3'd0;
	localparam logic [2:0] ACT_DATE_MONTH = 3'd1;
	localparam logic [2:0] ACT_DATE_DAY   = 3'd2;
	localparam logic [2:0] ACT_TS_YEAR    = 3'd3;
	localparam logic [2:0] ACT_TS_MONTH   = 3'd4;
	localparam logic [2:0] ACT_TS_DAY     = 3'd5;
	localparam logic [2:0] ACT_TS_HOUR    = 3'd6;
	localparam logic [2:0] ACT_TIME_HOUR  = 3'd7;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_INF   = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	localparam logic [23:0] DIV_DAY  = 24'd10546875;
	localparam logic [23:0] DIV_HOUR = 24'd3515625;
	localparam logic [23:0] DIV_400Y = 24'd146097;
	localparam logic [23:0] DIV_4Y   = 24'd1461;
	localparam logic [31:0] JD_2000     = 32'd2451545;
	localparam logic [33:0] DATE_JD_END = 34'd2147483494;
	localparam logic [31:0] EPOCH_GAP   = 32'd10957;
	localparam logic [31:0] HOUR_GAP    = 32'd262968;
	localparam logic [31:0] JD_SHIFT    = 32'd32044;
	localparam logic [31:0] YEAR_BASE   = 32'd6770;

	typedef struct packed {
		logic [2:0]  action;
		logic [1:0]  status;
		logic        neg;
		logic [53:0] num;
		logic [24:0] rem;
		logic [23:0] dvsr;
		logic [31:0] jw;
		logic [1:0]  yq;
		logic [31:0] yr;
		logic [31:0] period;
	} item_t;

	function automatic item_t div_steps(item_t x, int n);
		logic [25:0] t;
		logic        ge;
		item_t       r;
		r = x;
		for (int k = 0; k < 8; k++) begin
			if (k < n) begin
				t = {r.rem, r.num[53]};
				ge = (t >= {2'b00, r.dvsr});
				if (ge) t = t - {2'b00, r.dvsr};
				r.rem = t[24:0];
				r.num = {r.num[52:0], ge};
			end
		end
		return r;
	endfunction

	function automatic item_t decode(logic [2:0] action, logic [63:0] value);
		logic        hour;
		logic [53:0] u;
		logic [33:0] jd;
		item_t       r;
		r = '0;
		r.action = action;
		hour = (action == ACT_TS_HOUR) || (action == ACT_TIME_HOUR);
		u = hour ? value[63:10] : {{3{value[63]}}, value[63:13]};
		r.neg = value[63];
		r.num = value[63] ? ~u : u;
		r.dvsr = hour ? DIV_HOUR : DIV_DAY;
		jd = {{2{value[31]}}, value[31:0]} + {2'b00, JD_2000};
		if (action <= ACT_DATE_DAY) begin
			if (value == 64'hFFFF_FFFF_8000_0000 || value == 64'h0000_0000_7FFF_FFFF)
				r.status = ST_INF;
			else if (!(value[63:31] == '0 || value[63:31] == '1))
				r.status = ST_RANGE;
			else if (action == ACT_DATE_DAY)
				r.period = value[31:0] + EPOCH_GAP;
			else if (jd[33] || jd >= DATE_JD_END)
				r.status = ST_RANGE;
			else
				r.jw = jd[31:0];
		end else if (action != ACT_TIME_HOUR) begin
			if (value == 64'h8000_0000_0000_0000 || value == 64'h7FFF_FFFF_FFFF_FFFF)
				r.status = ST_INF;
		end
		return r;
	endfunction

	function automatic item_t post_quot(item_t x);
		logic [53:0] fq;
		logic [54:0] jdt;
		logic [31:0] j;
		item_t       r;
		r = x;
		fq = x.neg ? ~x.num : x.num;
		jdt = {fq[53], fq} + {23'd0, JD_2000};
		case (x.action)
			ACT_TS_DAY:    r.period = fq[31:0] + EPOCH_GAP;
			ACT_TS_HOUR:   r.period = fq[31:0] + HOUR_GAP;
			ACT_TIME_HOUR: r.period = fq[31:0];
			ACT_TS_YEAR, ACT_TS_MONTH: begin
				if (x.status == ST_OK && jdt[54:31] != '0)
					r.status = ST_RANGE;
				else
					r.jw = jdt[31:0];
			end
			default: ;
		endcase
		j = r.jw + JD_SHIFT;
		r.jw = j;
		r.num = {j, 22'd0};
		r.rem = '0;
		r.dvsr = DIV_400Y;
		return r;
	endfunction

	function automatic item_t post_400y(item_t x);
		logic [31:0] q;
		logic [19:0] ex;
		logic [1:0]  eq;
		logic [31:0] j;
		item_t       r;
		r = x;
		q = x.num[31:0];
		ex = {x.rem[17:0], 2'b11};
		if (ex >= 20'd438291)      eq = 2'd3;
		else if (ex >= 20'd292194) eq = 2'd2;
		else if (ex >= 20'd146097) eq = 2'd1;
		else                       eq = 2'd0;
		j = x.jw + 32'd60 + q + {q[30:0], 1'b0} + {30'd0, eq};
		r.jw = j;
		r.num = {j, 22'd0};
		r.rem = '0;
		r.dvsr = DIV_4Y;
		return r;
	endfunction

	function automatic item_t post_4y(item_t x);
		logic [10:0] jr;
		logic [12:0] jr4;
		item_t       r;
		r = x;
		jr = x.rem[10:0];
		jr4 = {jr, 2'b00};
		if (jr4 >= 13'd4383)      r.yq = 2'd3;
		else if (jr4 >= 13'd2922) r.yq = 2'd2;
		else if (jr4 >= 13'd1461) r.yq = 2'd1;
		else                      r.yq = 2'd0;
		r.yr = x.num[31:0];
		r.jw = {21'd0, jr} + ((r.yq != 2'd0) ? 32'd305 : 32'd306);
		return r;
	endfunction

	function automatic item_t year_day(item_t x);
		logic [10:0] v;
		logic [10:0] m;
		item_t       r;
		r = x;
		v = x.jw[10:0];
		m = (x.yq != 2'd0) ? 11'd365 : 11'd366;
		for (int k = 0; k < 4; k++) begin
			if (v >= m) v = v - m;
		end
		r.jw = {21'd0, v} + 32'd123;
		r.yr = {x.yr[29:0], 2'b00} + {30'd0, x.yq} - YEAR_BASE;
		return r;
	endfunction

	function automatic item_t finish(item_t x);
		logic [20:0] prod;
		logic [4:0]  mm;
		item_t       r;
		r = x;
		prod = {12'd0, x.jw[8:0]} * 21'd2141;
		mm = prod[20:16] + 5'd10;
		if (mm >= 5'd12) mm = mm - 5'd12;
		if (mm >= 5'd12) mm = mm - 5'd12;
		case (x.action)
			ACT_DATE_YEAR, ACT_TS_YEAR: r.period = x.yr;
			ACT_DATE_MONTH, ACT_TS_MONTH:
				r.period = {x.yr[28:0], 3'b000} + {x.yr[29:0], 2'b00} + {27'd0, mm};
			default: ;
		endcase
		if (x.status != ST_OK) r.period = '0;
		return r;
	endfunction

	function automatic item_t stage_fn(int i, item_t x);
		item_t r;
		if (i <= 9)       r = div_steps(x, 6);
		else if (i == 10) r = post_quot(x);
		else if (i <= 14) r = div_steps(x, 8);
		else if (i == 15) r = post_400y(x);
		else if (i <= 19) r = div_steps(x, 8);
		else if (i == 20) r = post_4y(x);
		else if (i == 21) r = year_day(x);
		else              r = finish(x);
		return r;
	endfunction

endpackage

@@ sv/epoch_period_bucket_transform.sv @@
// ----------------------------------------------------------------------------
// epoch_period_bucket_transform
// Calendar value to years, months, days or hours since 1970-01-01, or to the hour of day for a time of day.
// ----------------------------------------------------------------------------
// Input stream s_*: one transfer carries an action code and a 64-bit value
// (day count, microsecond timestamp or microsecond time of day).
// Output stream m_*: one transfer per input carrying the period and status.
// Throughput: one item per cycle while the receiver does not stall; the
// 54-bit floor division by the day or hour constant runs six quotient bits
// per stage, and the calendar divisions by 146097 and 1461 eight bits per
// stage, so the pipeline holds 23 stages.
// Each stage loads when empty or when its content moves on, so bubbles
// collapse and input is still taken while a result waits at the output.
// When the receiver stalls, the output holds and the pipeline fills up;
// s_tready drops once every stage is occupied. Nothing is lost or repeated.
// Reset clears all stage valid bits; no output is presented until new input.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module epoch_period_bucket_transform (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // action[2:0], value[66:3], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // period[31:0], status[33:32], zero pad
);
	import epbt_pkg::*;

	item_t pipe_s [1:NS];
	item_t nxt    [1:NS];
	logic  vld_s  [1:NS];
	logic  ld     [1:NS];

	assign ld[NS] = !vld_s[NS] || m_tready;

	genvar gi;
	generate
		for (gi = 1; gi <= NS; gi++) begin : g_stage
			if (gi < NS) begin : g_ld
				assign ld[gi] = !vld_s[gi] || ld[gi+1];
			end
			if (gi == 1) begin : g_in
				always_comb begin
					nxt[gi] = decode(s_tdata[2:0], s_tdata[66:3]);
				end
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						vld_s[gi] <= 1'b0;
					end else if (ld[gi]) begin
						vld_s[gi] <= s_tvalid;
					end
				end
				always_ff @(posedge clk) begin
					if (ld[gi] && s_tvalid) begin
						pipe_s[gi] <= nxt[gi];
					end
				end
			end else begin : g_mid
				always_comb begin
					nxt[gi] = stage_fn(gi - 1, pipe_s[gi-1]);
				end
				always_ff @(posedge clk or negedge arst_n) begin
					if (!arst_n) begin
						vld_s[gi] <= 1'b0;
					end else if (ld[gi]) begin
						vld_s[gi] <= vld_s[gi-1];
					end
				end
				always_ff @(posedge clk) begin
					if (ld[gi] && vld_s[gi-1]) begin
						pipe_s[gi] <= nxt[gi];
					end
				end
			end
		end
	endgenerate

	assign s_tready = ld[1];
	assign m_tvalid = vld_s[NS];
	assign m_tdata  = {6'd0, pipe_s[NS].status, pipe_s[NS].period};

	`ASSERT_IMP(a_full_stall, !s_tready, vld_s[NS] && !m_tready)
	`ASSERT_NXT(a_take_in, s_tvalid && s_tready, vld_s[1])
	`ASSERT_NXT(a_out_hold, vld_s[NS] && !m_tready, vld_s[NS])
	`ASSERT_IMP(a_err_zero, m_tvalid && m_tdata[33:32] != ST_OK, m_tdata[31:0] == '0)

endmodule
